/* hdl/rrpm_pkg.sv */
// Shared types and constants of the ring read pointer manager.
package rrpm_pkg;

  // Operation requested by one input word.
  typedef enum logic [2:0] {
    MODE_SET_WRITE = 3'd0,
    MODE_RESTART   = 3'd1,
    MODE_PEEK      = 3'd2,
    MODE_SPAN      = 3'd3,
    MODE_SKIP      = 3'd4,
    MODE_READ      = 3'd5,
    MODE_CLEAR     = 3'd6,
    MODE_STATUS    = 3'd7
  } mode_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_RING_SIZE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RESERVE   = 1'b1;

  // Register values after reset.
  localparam longint unsigned RingSizeReset = 65536;
  localparam longint unsigned ReserveReset  = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic commit;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } ctrl_sts_t;

endpackage

/* hdl/rrpm_if.sv */
// Request and response channel interfaces of the ring read pointer manager.
interface rrpm_req_if #(
  parameter int unsigned OFFSET_BITS = 24
);
  import rrpm_pkg::*;

  logic                 valid;
  logic                 ready;
  mode_e                mode;
  logic [OFFSET_BITS-1:0] offset;
  logic [OFFSET_BITS:0]   length;

  modport source (output valid, mode, offset, length, input ready);
  modport sink   (input valid, mode, offset, length, output ready);
endinterface

interface rrpm_rsp_if #(
  parameter int unsigned OFFSET_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic [OFFSET_BITS-1:0] first_addr;
  logic [OFFSET_BITS-1:0] first_len;
  logic [OFFSET_BITS-1:0] second_len;
  logic [OFFSET_BITS-1:0] load_bytes;
  logic [OFFSET_BITS-1:0] free_bytes;
  logic [OFFSET_BITS-1:0] read_pos;

  modport source (output valid, status, first_addr, first_len, second_len, load_bytes,
                  free_bytes, read_pos, input ready);
  modport sink   (input valid, status, first_addr, first_len, second_len, load_bytes,
                  free_bytes, read_pos, output ready);
endinterface

/* hdl/rrpm_ctrl.sv */
// Sequencing controller of the ring read pointer manager.
module rrpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output rrpm_pkg::ctrl_cmd_t cmd_o,
  input  rrpm_pkg::ctrl_sts_t sts_i
);
  import rrpm_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // A new word is taken only between operations.
  assign in_ready_o = (state_q == ST_IDLE);

  // Commands for each phase of the operation.
  always_comb begin
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.check   = (state_q == ST_CHECK);
    cmd_o.commit  = (state_q == ST_COMMIT);
    cmd_o.finish  = (state_q == ST_FINISH) && !sts_i.out_busy;
  end

  // Next state: the finish phase waits for room in the output register.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_FINISH;
      ST_FINISH: if (!sts_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted word always starts the check phase.
  a_capture_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == ST_CHECK)
    else $error("accepted word did not enter the check phase");

  // Check is always followed by commit, then by finish.
  a_check_commit_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.check |=> cmd_o.commit ##1 state_q == ST_FINISH)
    else $error("phase sequence broken");

  // A result is only loaded when the output register has room.
  a_finish_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !sts_i.out_busy && state_q == ST_FINISH)
    else $error("result loaded into a busy output register");

endmodule

/* hdl/rrpm_dp.sv */
// Datapath of the ring read pointer manager: registers, pointer arithmetic, result.
module rrpm_dp #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrpm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [OFFSET_BITS:0]           cfg_wdata_i,
  input  rrpm_pkg::mode_e                mode_i,
  input  logic [OFFSET_BITS-1:0]         offset_i,
  input  logic [OFFSET_BITS:0]           length_i,
  input  rrpm_pkg::ctrl_cmd_t            cmd_i,
  output rrpm_pkg::ctrl_sts_t            sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           status_o,
  output logic [OFFSET_BITS-1:0]         first_addr_o,
  output logic [OFFSET_BITS-1:0]         first_len_o,
  output logic [OFFSET_BITS-1:0]         second_len_o,
  output logic [OFFSET_BITS-1:0]         load_bytes_o,
  output logic [OFFSET_BITS-1:0]         free_bytes_o,
  output logic [OFFSET_BITS-1:0]         read_pos_o
);
  import rrpm_pkg::*;

  localparam int unsigned W = OFFSET_BITS;

  // (a - b) mod size for a, b below size.
  function automatic logic [W:0] ring_dist(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W:0] sz);
    logic [W:0] r;
    if (a >= b) r = {1'b0, a} - {1'b0, b};
    else        r = {1'b0, a} + sz - {1'b0, b};
    return r;
  endfunction

  // Configuration and pointer state.
  logic [W:0]   size_q;
  logic [W-1:0] rsv_q;
  logic [W-1:0] rd_q, wr_q;
  logic [W-1:0] rd_d, wr_d;

  // Captured word.
  mode_e        mode_q;
  logic [W-1:0] ofs_q;
  logic [W:0]   len_q;

  // Check phase results.
  logic         cfg_ok_q;
  logic [W-1:0] maxl_q, cur_q, start_q, rd_adv_q;
  logic         wr_bad_q, ofs_bad_q;

  // Commit phase results.
  logic         refused_q;
  logic [W-1:0] addr_q, len1_q, len2_q;

  // Output register.
  logic         out_valid_q;
  logic         status_q;
  logic [W-1:0] first_addr_q, first_len_q, second_len_q;
  logic [W-1:0] load_q, free_q, read_pos_q;

  // Check phase: configuration validity, current load, region start.
  logic         cfg_ok_c;
  logic [W:0]   maxl_c, cur_c, wload_c, start_sum_c, start_c;
  logic [W+1:0] adv_sum_c, adv_c;
  logic [W-1:0] eo_c;

  always_comb begin
    cfg_ok_c = (size_q >= (W+1)'(2)) && (size_q <= {1'b1, {W{1'b0}}}) &&
               (rsv_q != '0) && ({1'b0, rsv_q} < size_q);
    maxl_c   = size_q - {1'b0, rsv_q};
    cur_c    = ring_dist(wr_q, rd_q, size_q);
    wload_c  = ring_dist(ofs_q, rd_q, size_q);
    eo_c     = (mode_q == MODE_READ) ? '0 : ofs_q;
    start_sum_c = {1'b0, rd_q} + {1'b0, eo_c};
    start_c  = (start_sum_c >= size_q) ? start_sum_c - size_q : start_sum_c;
    adv_sum_c = {2'b00, rd_q} + {1'b0, len_q};
    adv_c    = (adv_sum_c >= {1'b0, size_q}) ? adv_sum_c - {1'b0, size_q} : adv_sum_c;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      ofs_q  <= offset_i;
      len_q  <= length_i;
    end
    if (cmd_i.check) begin
      cfg_ok_q  <= cfg_ok_c;
      maxl_q    <= maxl_c[W-1:0];
      cur_q     <= cur_c[W-1:0];
      start_q   <= start_c[W-1:0];
      rd_adv_q  <= adv_c[W-1:0];
      ofs_bad_q <= ({1'b0, ofs_q} >= size_q);
      wr_bad_q  <= ({1'b0, ofs_q} >= size_q) || (wload_c > maxl_c);
    end
  end

  // Commit phase: decide acceptance, region and new pointers.
  logic         refused_c, avail_c, span_fit_c;
  logic [W-1:0] addr_c, len1_c, len2_c, eo_k;
  logic [W:0]   to_end_c, clip_c;

  always_comb begin
    eo_k       = (mode_q == MODE_READ) ? '0 : ofs_q;
    avail_c    = (eo_k <= cur_q) && (len_q <= {1'b0, cur_q - eo_k});
    to_end_c   = size_q - {1'b0, start_q};
    span_fit_c = (len_q <= to_end_c);
    clip_c     = span_fit_c ? len_q : to_end_c;
    refused_c  = 1'b0;
    addr_c     = '0;
    len1_c     = '0;
    len2_c     = '0;
    rd_d       = rd_q;
    wr_d       = wr_q;
    if (!cfg_ok_q) begin
      refused_c = 1'b1;
    end else begin
      unique case (mode_q)
        MODE_SET_WRITE: begin
          if (wr_bad_q) refused_c = 1'b1;
          else          wr_d = ofs_q;
        end
        MODE_RESTART: begin
          if (ofs_bad_q) begin
            refused_c = 1'b1;
          end else begin
            rd_d = ofs_q;
            wr_d = ofs_q;
          end
        end
        MODE_PEEK, MODE_READ: begin
          if (len_q != '0) begin
            if (!avail_c) begin
              refused_c = 1'b1;
            end else begin
              addr_c = start_q;
              len1_c = clip_c[W-1:0];
              len2_c = W'(len_q - clip_c);
              if (mode_q == MODE_READ) rd_d = rd_adv_q;
            end
          end
        end
        MODE_SPAN: begin
          if (!avail_c || !span_fit_c) begin
            refused_c = 1'b1;
          end else begin
            addr_c = start_q;
            len1_c = len_q[W-1:0];
          end
        end
        MODE_SKIP: begin
          if (len_q > {1'b0, cur_q}) refused_c = 1'b1;
          else                       rd_d = rd_adv_q;
        end
        MODE_CLEAR:  rd_d = wr_q;
        MODE_STATUS: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      refused_q <= refused_c;
      addr_q    <= addr_c;
      len1_q    <= len1_c;
      len2_q    <= len2_c;
    end
  end

  // Configuration registers and pointers; any register write zeroes the pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= (W+1)'(RingSizeReset);
      rsv_q  <= W'(ReserveReset);
      rd_q   <= '0;
      wr_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RING_SIZE) size_q <= cfg_wdata_i;
      else                            rsv_q  <= cfg_wdata_i[W-1:0];
      rd_q <= '0;
      wr_q <= '0;
    end else if (cmd_i.commit) begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  // Finish phase: load and free space from the updated pointers.
  logic [W:0]   fin_dist_c;
  logic [W-1:0] load_c, free_c;

  always_comb begin
    fin_dist_c = ring_dist(wr_q, rd_q, size_q);
    load_c     = cfg_ok_q ? fin_dist_c[W-1:0] : '0;
    free_c     = (cfg_ok_q && (load_c < maxl_q)) ? maxl_q - load_c : '0;
  end

  // Output register parts the result from the next operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q     <= refused_q;
      first_addr_q <= addr_q;
      first_len_q  <= len1_q;
      second_len_q <= len2_q;
      load_q       <= load_c;
      free_q       <= free_c;
      read_pos_q   <= rd_q;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign first_addr_o   = first_addr_q;
  assign first_len_o    = first_len_q;
  assign second_len_o   = second_len_q;
  assign load_bytes_o   = load_q;
  assign free_bytes_o   = free_q;
  assign read_pos_o     = read_pos_q;

  // With a valid configuration both pointers stay inside the ring.
  a_ptr_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ok_c |-> ({1'b0, rd_q} < size_q) && ({1'b0, wr_q} < size_q))
    else $error("pointer outside the ring");

  // An invalid configuration leaves the pointers untouched.
  a_invalid_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !cfg_ok_q && !cfg_we_i |=> rd_q == $past(rd_q) && wr_q == $past(wr_q))
    else $error("pointers changed under an invalid configuration");

  // A refused word carries no region.
  a_refused_no_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> first_addr_o == '0 && first_len_o == '0 &&
                                second_len_o == '0)
    else $error("refused word carries a region");

endmodule

/* hdl/ring_read_pointer_manager.sv */
// Top level of the ring read pointer manager.
//
// Consumer-side read and write offset control for a ring buffer with a reserve. The edge that
// accepts a request word captures it; then come check (configuration validity, current load,
// region start), commit (accept or refuse, update the pointers) and finish (load and free space
// into the output register), each a registered phase, and finish loads the response word into
// the output register. The controller runs these phases in turn and takes a new request only
// when idle, so a new request is not accepted before the last one has finished; a response that
// is not taken holds the block in its finish phase. Configuration writes zero both offsets and
// are meant to arrive only while no request is in flight. After reset both offsets are zero,
// the ring holds 65536 bytes and the reserve is one byte.
module ring_read_pointer_manager #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rrpm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [OFFSET_BITS:0]         cfg_wdata_i,
  rrpm_req_if.sink                     req_i,
  rrpm_rsp_if.source                   rsp_o
);
  import rrpm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rrpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rrpm_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (req_i.mode),
    .offset_i     (req_i.offset),
    .length_i     (req_i.length),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .first_addr_o (rsp_o.first_addr),
    .first_len_o  (rsp_o.first_len),
    .second_len_o (rsp_o.second_len),
    .load_bytes_o (rsp_o.load_bytes),
    .free_bytes_o (rsp_o.free_bytes),
    .read_pos_o   (rsp_o.read_pos)
  );

endmodule

/* verif/ring_read_pointer_manager_test.sv */
// Self-checking testbench for the ring read pointer manager: directed table, random phases.
`timescale 1ns / 1ps

module ring_read_pointer_manager_test;
  import rrpm_pkg::*;

  localparam int unsigned OB = 24;

  // Wide enough for a sum of two offsets below the ring size.
  typedef logic [OB+1:0] wide_t;

  typedef struct packed {
    logic          status;
    logic [OB-1:0] first_addr;
    logic [OB-1:0] first_len;
    logic [OB-1:0] second_len;
    logic [OB-1:0] load_bytes;
    logic [OB-1:0] free_bytes;
    logic [OB-1:0] read_pos;
  } ptr_reply_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    mode_e              mode;
    logic [OB-1:0]      ofs;
    logic [OB:0]        len;
    logic [CfgIdxW-1:0] idx;
    logic [OB:0]        val;
    bit                 fixed;
    ptr_reply_t         want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [OB:0]        cfg_wdata;

  rrpm_req_if #(.OFFSET_BITS(OB)) req_if ();
  rrpm_rsp_if #(.OFFSET_BITS(OB)) rsp_if ();

  ring_read_pointer_manager #(.OFFSET_BITS(OB)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  always #1 clk_i = ~clk_i;

  // Own copy of the configuration and of both offsets.
  logic [OB:0]   ring_size_q = RingSizeReset[OB:0];
  logic [OB-1:0] reserve_q   = ReserveReset[OB-1:0];
  logic [OB-1:0] rd_ptr      = '0;
  logic [OB-1:0] wr_ptr      = '0;

  ptr_reply_t pending_replies[$];
  stim_row_t  dir_rows[$];
  int         mismatch_cnt = 0;
  int         burst_left   = 0;

  function automatic bit ring_cfg_valid();
    if (ring_size_q < 2 || ring_size_q > (1 << OB)) return 1'b0;
    return reserve_q >= 1 && reserve_q < ring_size_q;
  endfunction

  // Distance from r forward to w around the ring.
  function automatic wide_t ring_dist(wide_t w, wide_t r);
    return (w >= r) ? w - r : w + ring_size_q - r;
  endfunction

  function automatic wide_t ring_add(wide_t a, wide_t b);
    wide_t s;
    s = a + b;
    return (s >= ring_size_q) ? s - ring_size_q : s;
  endfunction

  // Applies one request word to the offsets and returns the reply it should produce.
  function automatic ptr_reply_t advance_pointers(mode_e m, logic [OB-1:0] ofs,
                                                  logic [OB:0] len);
    ptr_reply_t r;
    wide_t      max_load, cur, off_w, len_w, start, to_end, len1, load, fr;
    r = '0;
    r.status = 1'b1;
    if (ring_cfg_valid()) begin
      max_load = ring_size_q - reserve_q;
      cur      = ring_dist(wr_ptr, rd_ptr);
      off_w    = ofs;
      len_w    = len;
      r.status = 1'b0;
      case (m)
        MODE_SET_WRITE: begin
          if (off_w >= ring_size_q || ring_dist(off_w, rd_ptr) > max_load) r.status = 1'b1;
          else wr_ptr = ofs;
        end
        MODE_RESTART: begin
          if (off_w >= ring_size_q) begin
            r.status = 1'b1;
          end else begin
            rd_ptr = ofs;
            wr_ptr = ofs;
          end
        end
        MODE_PEEK, MODE_SPAN, MODE_READ: begin
          if (m == MODE_READ) off_w = '0;
          // A zero-length peek or read passes without an availability check.
          if (len_w != 0 || m == MODE_SPAN) begin
            if (off_w > cur || len_w > cur - off_w) begin
              r.status = 1'b1;
            end else begin
              start  = ring_add(rd_ptr, off_w);
              to_end = ring_size_q - start;
              if (m == MODE_SPAN) begin
                // A span must not cross the buffer end.
                if (len_w > to_end) begin
                  r.status = 1'b1;
                end else begin
                  r.first_addr = start[OB-1:0];
                  r.first_len  = len_w[OB-1:0];
                end
              end else begin
                len1         = (len_w <= to_end) ? len_w : to_end;
                r.first_addr = start[OB-1:0];
                r.first_len  = len1[OB-1:0];
                r.second_len = len_w[OB-1:0] - len1[OB-1:0];
                if (m == MODE_READ) begin
                  start  = ring_add(rd_ptr, len_w);
                  rd_ptr = start[OB-1:0];
                end
              end
            end
          end
        end
        MODE_SKIP: begin
          if (len_w > cur) begin
            r.status = 1'b1;
          end else begin
            start  = ring_add(rd_ptr, len_w);
            rd_ptr = start[OB-1:0];
          end
        end
        MODE_CLEAR: rd_ptr = wr_ptr;
        default: ;
      endcase
      load         = ring_dist(wr_ptr, rd_ptr);
      fr           = (load >= max_load) ? '0 : max_load - load;
      r.load_bytes = load[OB-1:0];
      r.free_bytes = fr[OB-1:0];
    end
    r.read_pos = rd_ptr;
    return r;
  endfunction

  function automatic ptr_reply_t reply(logic st, logic [OB-1:0] ld, logic [OB-1:0] fr,
                                       logic [OB-1:0] rp);
    ptr_reply_t r;
    r            = '0;
    r.status     = st;
    r.load_bytes = ld;
    r.free_bytes = fr;
    r.read_pos   = rp;
    return r;
  endfunction

  function automatic stim_row_t word_row(mode_e m, logic [OB-1:0] ofs, logic [OB:0] len);
    stim_row_t row;
    row       = '{kind: ROW_WORD, mode: m, ofs: ofs, len: len, idx: '0, val: '0,
                  fixed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t fixed_row(mode_e m, logic [OB-1:0] ofs, logic [OB:0] len,
                                          ptr_reply_t want);
    stim_row_t row;
    row       = word_row(m, ofs, len);
    row.fixed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [OB:0] val);
    stim_row_t row;
    row      = word_row(MODE_STATUS, '0, '0);
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  task automatic check_field(string name, logic [OB-1:0] want, logic [OB-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Drops valid and waits until every reply word has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Register write while the block is idle; both offsets return to zero.
  task automatic write_ring_reg(logic [CfgIdxW-1:0] idx, logic [OB:0] val);
    wait_drained();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == CFG_RING_SIZE) ring_size_q = val;
    else reserve_q = val[OB-1:0];
    rd_ptr = '0;
    wr_ptr = '0;
  endtask

  // Sends one request word in bursts with random gaps and records its reply.
  task automatic send_word(mode_e m, logic [OB-1:0] ofs, logic [OB:0] len, bit fixed,
                           ptr_reply_t fixed_reply);
    ptr_reply_t pred;
    int         gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    req_if.valid  <= 1'b1;
    req_if.mode   <= m;
    req_if.offset <= ofs;
    req_if.length <= len;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = advance_pointers(m, ofs, len);
    pending_replies.push_back(fixed ? fixed_reply : pred);
  endtask

  // Random word, mostly in range for the current offsets, sometimes just past or raw.
  task automatic send_random_word();
    mode_e         m;
    logic [OB-1:0] ofs;
    logic [OB:0]   len;
    wide_t         sz, cur, max_load, start, to_end, lim;
    int            pick, noise;
    ptr_reply_t    none;
    none  = '0;
    sz    = ring_size_q;
    cur   = ring_cfg_valid() ? ring_dist(wr_ptr, rd_ptr) : '0;
    max_load = ring_cfg_valid() ? sz - reserve_q : '0;
    pick  = $urandom_range(0, 15);
    case (pick)
      0, 1, 2, 3, 14: m = MODE_SET_WRITE;
      4:              m = MODE_RESTART;
      5, 6:           m = MODE_PEEK;
      7, 8:           m = MODE_SPAN;
      9:              m = MODE_SKIP;
      10, 11:         m = MODE_READ;
      12:             m = MODE_CLEAR;
      default:        m = MODE_STATUS;
    endcase
    ofs   = OB'($urandom);
    len   = (OB+1)'($urandom);
    noise = $urandom_range(0, 9);
    if (ring_cfg_valid() && noise > 1) begin
      case (m)
        MODE_SET_WRITE: begin
          start = ring_add(rd_ptr, $urandom_range(0, max_load));
          ofs   = start[OB-1:0];
        end
        MODE_RESTART: ofs = OB'($urandom_range(0, sz - 1));
        MODE_PEEK, MODE_SPAN: begin
          ofs = OB'($urandom_range(0, cur));
          lim = cur - ofs;
          if (m == MODE_SPAN && $urandom_range(0, 1)) begin
            start  = ring_add(rd_ptr, ofs);
            to_end = sz - start;
            if (to_end < lim) lim = to_end;
          end
          len = (OB+1)'($urandom_range(0, lim));
        end
        MODE_READ, MODE_SKIP: len = (OB+1)'($urandom_range(0, cur));
        default: ;
      endcase
    end else if (ring_cfg_valid() && noise == 1) begin
      // Just past the limits.
      if (sz < (1 << OB)) ofs = sz[OB-1:0];
      lim = cur + 1;
      len = lim[OB:0];
    end
    send_word(m, ofs, len, 1'b0, none);
  endtask

  // Receiver: ready pattern that switches at random between four stall modes.
  initial begin
    int stall_mode;
    int phase_left;
    int cyc;
    stall_mode = 0;
    phase_left = 0;
    cyc        = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      cyc++;
      case (stall_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= $urandom_range(0, 1);
        2:       rsp_if.ready <= (cyc % 5 == 0);
        default: rsp_if.ready <= (cyc % 8 == 0);
      endcase
    end
  end

  // Reply checker: each accepted reply word against the oldest expectation.
  always @(posedge clk_i) begin
    ptr_reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply word with no request pending");
        mismatch_cnt++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", OB'(want.status), OB'(rsp_if.status));
        check_field("first_addr", want.first_addr, rsp_if.first_addr);
        check_field("first_len", want.first_len, rsp_if.first_len);
        check_field("second_len", want.second_len, rsp_if.second_len);
        check_field("load_bytes", want.load_bytes, rsp_if.load_bytes);
        check_field("free_bytes", want.free_bytes, rsp_if.free_bytes);
        check_field("read_pos", want.read_pos, rsp_if.read_pos);
      end
    end
  end

  // Stimulus: reset, directed table, then random phases over several ring settings.
  initial begin
    logic [OB:0] sz;
    logic [OB:0] res;
    int          cnt;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    req_if.valid  <= 1'b0;
    req_if.mode   <= MODE_STATUS;
    req_if.offset <= '0;
    req_if.length <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset ring of 65536 bytes with a one-byte reserve.
    dir_rows.push_back(fixed_row(MODE_STATUS, 0, 0, reply(0, 0, 65535, 0)));
    dir_rows.push_back(fixed_row(MODE_PEEK, 0, 0, reply(0, 0, 65535, 0)));
    dir_rows.push_back(fixed_row(MODE_PEEK, 0, 1, reply(1, 0, 65535, 0)));
    dir_rows.push_back(fixed_row(MODE_SPAN, 0, 0, reply(0, 0, 65535, 0)));
    dir_rows.push_back(fixed_row(MODE_SPAN, 1, 0, reply(1, 0, 65535, 0)));
    dir_rows.push_back(fixed_row(MODE_SET_WRITE, 65536, 0, reply(1, 0, 65535, 0)));
    dir_rows.push_back(fixed_row(MODE_SET_WRITE, 65535, 0, reply(0, 65535, 0, 0)));
    dir_rows.push_back(fixed_row(MODE_RESTART, 24'hFFFFFF, 0, reply(1, 65535, 0, 0)));
    dir_rows.push_back(fixed_row(MODE_RESTART, 65530, 0, reply(0, 0, 65535, 65530)));
    // Data around the wrap point.
    dir_rows.push_back(word_row(MODE_SET_WRITE, 100, 0));
    dir_rows.push_back(word_row(MODE_PEEK, 2, 10));
    dir_rows.push_back(word_row(MODE_SPAN, 0, 10));
    dir_rows.push_back(word_row(MODE_SPAN, 6, 100));
    dir_rows.push_back(word_row(MODE_READ, 24'hFFFFFF, 8));
    dir_rows.push_back(word_row(MODE_SKIP, 0, 25'h1FFFFFF));
    dir_rows.push_back(word_row(MODE_SKIP, 0, 3));
    dir_rows.push_back(word_row(MODE_PEEK, 24'hFFFFFF, 25'h1000000));
    dir_rows.push_back(word_row(MODE_CLEAR, 0, 0));
    dir_rows.push_back(word_row(MODE_READ, 0, 0));
    // Smallest ring.
    dir_rows.push_back(reg_row(CFG_RING_SIZE, 2));
    dir_rows.push_back(fixed_row(MODE_STATUS, 0, 0, reply(0, 0, 1, 0)));
    dir_rows.push_back(fixed_row(MODE_SET_WRITE, 1, 0, reply(0, 1, 0, 0)));
    dir_rows.push_back(word_row(MODE_READ, 0, 1));
    // Reserve as large as the ring: invalid, status refused too.
    dir_rows.push_back(reg_row(CFG_RESERVE, 2));
    dir_rows.push_back(fixed_row(MODE_STATUS, 0, 0, reply(1, 0, 0, 0)));
    // Largest ring with the largest reserve; the top write bit is dropped.
    dir_rows.push_back(reg_row(CFG_RING_SIZE, 25'h1000000));
    dir_rows.push_back(reg_row(CFG_RESERVE, 25'h1FFFFFF));
    dir_rows.push_back(fixed_row(MODE_STATUS, 0, 0, reply(0, 0, 1, 0)));
    // Ring larger than the offsets can address.
    dir_rows.push_back(reg_row(CFG_RING_SIZE, 25'h1FFFFFF));
    dir_rows.push_back(fixed_row(MODE_RESTART, 0, 0, reply(1, 0, 0, 0)));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        write_ring_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].mode, dir_rows[i].ofs, dir_rows[i].len, dir_rows[i].fixed,
                  dir_rows[i].want);
      end
    end

    for (int p = 0; p < 17; p++) begin
      case (p)
        0:  begin sz = 16; res = 3; end
        1:  begin sz = 2; res = 1; end
        2:  begin sz = 7; res = 6; end
        3:  begin sz = 1 << OB; res = 1; end
        4:  begin sz = 0; res = 1; end
        5:  begin sz = $urandom_range(2, 300); res = $urandom_range(1, sz - 1); end
        6:  begin sz = 1 << OB; res = $urandom_range(1, (1 << OB) - 1); end
        7:  begin sz = 1; res = 1; end
        8:  begin sz = $urandom_range(2, 64); res = $urandom_range(1, sz - 1); end
        9:  begin sz = 50; res = 50; end
        10: begin sz = $urandom_range(2, 1000); res = $urandom_range(1, sz - 1); end
        11: begin sz = 50; res = 0; end
        12: begin sz = (1 << OB) + 1; res = 5; end
        13: begin sz = $urandom_range(2, 1 << OB); res = $urandom_range(1, sz - 1); end
        14: begin sz = 65536; res = 1; end
        15: begin sz = $urandom_range(2, 20); res = $urandom_range(1, sz - 1); end
        default: begin sz = 1 << OB; res = (1 << OB) - 1; end
      endcase
      // The reserve register keeps only the low bits, so the top bit is noise.
      res[OB] = $urandom_range(0, 1);
      if ($urandom_range(0, 1)) begin
        write_ring_reg(CFG_RING_SIZE, sz);
        write_ring_reg(CFG_RESERVE, res);
      end else begin
        write_ring_reg(CFG_RESERVE, res);
        write_ring_reg(CFG_RING_SIZE, sz);
      end
      cnt = ring_cfg_valid() ? 90 : 16;
      repeat (cnt) send_random_word();
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
